// ===== hdl/pdbd_pkg.sv =====
package pdbd_pkg;

  // Dictionary geometry
  localparam int unsigned DictDepth = 111;
  localparam int unsigned DictIdxW  = 7;
  localparam int unsigned ByteW     = 8;

  // Index that marks the end of the stream in the long code
  localparam logic [DictIdxW-1:0] END_INDEX = 7'd111;

  // Bit of dictionary entry 0 that turns delta mode on
  localparam int unsigned DeltaBit = 6;

  // Index offsets of the code classes
  localparam logic [DictIdxW-1:0] OFS_SHORT2 = 7'd4;
  localparam logic [DictIdxW-1:0] OFS_SHORT3 = 7'd8;
  localparam logic [DictIdxW-1:0] OFS_MID5   = 7'd16;
  localparam logic [DictIdxW-1:0] OFS_LONG6  = 7'd48;

  // Kind of input item
  localparam logic REQ_DICT_WRITE = 1'b0;
  localparam logic REQ_CODE_BIT   = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [DictIdxW-1:0] dict_index;
    logic [ByteW-1:0]    dict_value;
    logic                code_bit;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             stream_end;
  } out_item_t;

endpackage

// ===== hdl/pdbd_ram.sv =====
module pdbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 111
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/prefix_dictionary_byte_decoder_unit.sv =====
// Prefix-code byte decoder: takes one item per clock, either a dictionary
// write (entries 0..110, higher indexes are dropped) or one code bit, most
// significant first. Codes are assembled in a shift register; when the bit
// that completes a dictionary code is taken, the entry is read from a
// 111 x 8 RAM with registered read into the second stage, and the byte
// (after the optional delta step against the byte two places back) is then
// written to the output register once that register can take it. The
// sustained rate is one item per cycle, limited only by out_ready. The end
// code gives one result with stream_end set and out_byte zero; later code
// bits give nothing until reset. Entry 0 must be written before the first
// byte is decoded, since its bit 6 selects delta mode.
module prefix_dictionary_byte_decoder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdbd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdbd_pkg::out_item_t  out_data
);

  localparam int unsigned IW = pdbd_pkg::DictIdxW;
  localparam int unsigned BW = pdbd_pkg::ByteW;

  // Decode-side state
  logic [9:0]    code_bits_r, code_bits_nxt;
  logic [3:0]    code_len_r,  code_len_nxt;
  logic          ended_r,     ended_nxt;
  logic          delta_r,     delta_nxt;

  // Second stage: waiting for the RAM data
  logic          s1_valid_r,  s1_valid_nxt;
  logic          s1_end_r,    s1_end_nxt;
  logic          s1_lit_r,    s1_lit_nxt;
  logic [BW-1:0] s1_litv_r,   s1_litv_nxt;
  logic          s1_delta_r,  s1_delta_nxt;

  // Byte history and output register
  logic [BW-1:0] older_r,     older_nxt;
  logic [BW-1:0] newer_r,     newer_nxt;
  logic [1:0]    seen_r,      seen_nxt;
  logic          out_valid_r, out_valid_nxt;
  pdbd_pkg::out_item_t out_data_r, out_data_nxt;

  logic          in_acc;
  logic          s1_adv;
  logic          wr_acc;
  logic          bit_acc;
  logic [9:0]    v;
  logic [3:0]    len;
  logic          dec_emit;
  logic          dec_end;
  logic          dec_lit;
  logic          dec_done;
  logic [IW-1:0] dec_idx;
  logic          ram_re;
  logic [BW-1:0] ram_q;
  logic [BW-1:0] s1_val;
  logic [BW-1:0] s1_res;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign wr_acc   = in_acc && (in_data.req_type == pdbd_pkg::REQ_DICT_WRITE)
                    && (in_data.dict_index < IW'(pdbd_pkg::DictDepth));
  assign bit_acc  = in_acc && (in_data.req_type == pdbd_pkg::REQ_CODE_BIT)
                    && !ended_r;

  // Shift in the new bit and classify the code gathered so far
  assign v   = {code_bits_r[8:0], in_data.code_bit};
  assign len = code_len_r + 4'd1;

  always_comb begin
    dec_emit = 1'b0;
    dec_end  = 1'b0;
    dec_lit  = 1'b0;
    dec_idx  = '0;
    unique case (len)
      4'd4: begin
        if (v[3:2] == 2'b00 && v[1:0] != 2'b00) begin
          dec_emit = 1'b1;
          dec_idx  = {5'd0, v[1:0]};
        end
      end
      4'd5: begin
        if (v[4:3] == 2'b01 && !v[2]) begin
          dec_emit = 1'b1;
          dec_idx  = {5'd0, v[1:0]} + pdbd_pkg::OFS_SHORT2;
        end
      end
      4'd6: begin
        if (v[5:4] == 2'b01) begin
          dec_emit = 1'b1;
          dec_idx  = {4'd0, v[2:0]} + pdbd_pkg::OFS_SHORT3;
        end
      end
      4'd7: begin
        if (v[6:5] == 2'b10) begin
          dec_emit = 1'b1;
          dec_idx  = {2'd0, v[4:0]} + pdbd_pkg::OFS_MID5;
        end
      end
      4'd8: begin
        if (v[7:6] == 2'b11) begin
          dec_idx = {1'b0, v[5:0]} + pdbd_pkg::OFS_LONG6;
          if (dec_idx == pdbd_pkg::END_INDEX) begin
            dec_end = 1'b1;
          end else begin
            dec_emit = 1'b1;
          end
        end
      end
      4'd12: begin
        dec_emit = 1'b1;
        dec_lit  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign dec_done = dec_emit || dec_end;
  assign ram_re   = bit_acc && dec_emit && !dec_lit;

  // Advance the code register, the end flag and the delta-mode copy
  always_comb begin
    code_bits_nxt = code_bits_r;
    code_len_nxt  = code_len_r;
    ended_nxt     = ended_r;
    delta_nxt     = delta_r;
    if (bit_acc) begin
      if (dec_done) begin
        code_bits_nxt = '0;
        code_len_nxt  = '0;
      end else begin
        code_bits_nxt = v;
        code_len_nxt  = len;
      end
      if (dec_end) begin
        ended_nxt = 1'b1;
      end
    end
    if (wr_acc && in_data.dict_index == '0) begin
      delta_nxt = in_data.dict_value[pdbd_pkg::DeltaBit];
    end
  end

  // Load the second stage when a code completes, drop it once it moves on
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_end_nxt   = s1_end_r;
    s1_lit_nxt   = s1_lit_r;
    s1_litv_nxt  = s1_litv_r;
    s1_delta_nxt = s1_delta_r;
    if (bit_acc && dec_done) begin
      s1_valid_nxt = 1'b1;
      s1_end_nxt   = dec_end;
      s1_lit_nxt   = dec_lit;
      s1_litv_nxt  = v[7:0];
      s1_delta_nxt = delta_r;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Delta step against the byte two places back
  assign s1_val = s1_lit_r ? s1_litv_r : ram_q;
  assign s1_res = (s1_delta_r && seen_r == 2'd2) ? older_r - s1_val : s1_val;

  always_comb begin
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
      if (s1_end_r) begin
        out_data_nxt.out_byte   = '0;
        out_data_nxt.stream_end = 1'b1;
      end else begin
        out_data_nxt.out_byte   = s1_res;
        out_data_nxt.stream_end = 1'b0;
        older_nxt = newer_r;
        newer_nxt = s1_res;
        if (seen_r != 2'd2) begin
          seen_nxt = seen_r + 2'd1;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bits_r <= '0;
      code_len_r  <= '0;
      ended_r     <= 1'b0;
      delta_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      older_r     <= '0;
      newer_r     <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      code_bits_r <= code_bits_nxt;
      code_len_r  <= code_len_nxt;
      ended_r     <= ended_nxt;
      delta_r     <= delta_nxt;
      s1_valid_r  <= s1_valid_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_end_r   <= s1_end_nxt;
    s1_lit_r   <= s1_lit_nxt;
    s1_litv_r  <= s1_litv_nxt;
    s1_delta_r <= s1_delta_nxt;
    out_data_r <= out_data_nxt;
  end

  // Dictionary storage
  pdbd_ram #(
    .WIDTH (BW),
    .DEPTH (pdbd_pkg::DictDepth)
  ) u_dict (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (in_data.dict_index),
    .wdata (in_data.dict_value),
    .re    (ram_re),
    .raddr (dec_idx),
    .rdata (ram_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A dictionary lookup always lands in the second stage
  a_read_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> s1_valid_r && !s1_lit_r && !s1_end_r)
    else $error("dictionary read without second-stage item");

  // An end item in flight implies the end flag is set
  a_end_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_end_r |-> ended_r)
    else $error("end item without end flag");

  // Code register never gathers more than eleven bits
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    code_len_r <= 4'd11)
    else $error("code length out of range");

  // Byte counter saturates at two
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 2'd3)
    else $error("byte counter overflow");

  // A stalled second stage keeps the input side closed
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while second stage stalled");

endmodule

// ===== dv/tb_prefix_dictionary_byte_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_prefix_dictionary_byte_decoder_unit;

  localparam int unsigned RandomItems = 360;
  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned ReportMax   = 10;

  // One line of the directed plan: a dictionary write or a run of code bits
  typedef struct packed {
    logic                logic_pad_unused_never;
  } unused_t;

  typedef struct packed {
    logic                is_write;
    logic [6:0]          idx;
    logic [7:0]          val;
    logic [11:0]         bits;
    logic [3:0]          nbits;
    logic                typed;
    pdbd_pkg::out_item_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  pdbd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  pdbd_pkg::out_item_t out_data;

  prefix_dictionary_byte_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Decoder mirror
  logic [7:0]  dict_mirror [pdbd_pkg::DictDepth];
  logic [9:0]  code_acc;
  logic [3:0]  code_len;
  logic [7:0]  hist_older;
  logic [7:0]  hist_newer;
  logic [1:0]  out_count;
  bit          stream_done;

  pdbd_pkg::out_item_t expected_bytes [$];
  plan_row_t           plan [$];
  int unsigned         mismatches;
  int unsigned         results_seen;
  int unsigned         fed_items;
  int unsigned         cycle_count;
  int unsigned         send_calm;
  int unsigned         recv_calm;
  bit                  end_allowed;
  pdbd_pkg::out_item_t want_now;

  // Apply one item to the mirror and return the byte it completes, if any
  task automatic predict_item(input pdbd_pkg::in_item_t it, output bit got,
                              output pdbd_pkg::out_item_t res);
    logic [9:0] acc;
    logic [3:0] len;
    logic [1:0] top;
    logic [6:0] idx;
    logic [7:0] byte_val;
    logic [7:0] sent;
    bit         hit;
    got = 1'b0;
    res = '0;
    hit = 1'b0;
    byte_val = '0;
    if (it.req_type == pdbd_pkg::REQ_DICT_WRITE) begin
      if (it.dict_index < pdbd_pkg::DictDepth) dict_mirror[it.dict_index] = it.dict_value;
      return;
    end
    if (stream_done) return;
    acc = {code_acc[8:0], it.code_bit};
    len = code_len + 4'd1;
    code_acc = acc;
    code_len = len;
    if (len == 4'd12) begin
      // literal escape: 0000 and eight raw bits
      hit = 1'b1;
      byte_val = acc[7:0];
    end else if (len >= 4'd2 && len <= 4'd8) begin
      top = 2'(acc >> (len - 4'd2));
      case (top)
        2'd0: begin
          if (len == 4'd4 && acc[1:0] != 2'd0) begin
            hit = 1'b1;
            byte_val = dict_mirror[7'(acc[1:0])];
          end
        end
        2'd1: begin
          if (len == 4'd5 && !acc[2]) begin
            hit = 1'b1;
            byte_val = dict_mirror[7'(acc[1:0]) + pdbd_pkg::OFS_SHORT2];
          end else if (len == 4'd6) begin
            hit = 1'b1;
            byte_val = dict_mirror[7'(acc[2:0]) + pdbd_pkg::OFS_SHORT3];
          end
        end
        2'd2: begin
          if (len == 4'd7) begin
            hit = 1'b1;
            byte_val = dict_mirror[7'(acc[4:0]) + pdbd_pkg::OFS_MID5];
          end
        end
        default: begin
          if (len == 4'd8) begin
            idx = 7'(acc[5:0]) + pdbd_pkg::OFS_LONG6;
            code_acc = '0;
            code_len = '0;
            if (idx == pdbd_pkg::END_INDEX) begin
              stream_done = 1'b1;
              got = 1'b1;
              res.out_byte = '0;
              res.stream_end = 1'b1;
              return;
            end
            hit = 1'b1;
            byte_val = dict_mirror[idx];
          end
        end
      endcase
    end
    if (!hit) return;
    code_acc = '0;
    code_len = '0;
    // delta step against the byte two places back, once two bytes are out
    sent = byte_val;
    if (dict_mirror[0][pdbd_pkg::DeltaBit] && out_count == 2'd2) sent = hist_older - byte_val;
    hist_older = hist_newer;
    hist_newer = sent;
    if (out_count != 2'd2) out_count = out_count + 2'd1;
    got = 1'b1;
    res.out_byte = sent;
    res.stream_end = 1'b0;
  endtask

  // Mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int unsigned idle_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item from a falling edge, hold it until taken, return at a falling edge
  task automatic send_item(input pdbd_pkg::in_item_t it, input bit typed,
                           input pdbd_pkg::out_item_t want);
    int unsigned         gap;
    bit                  got;
    bit                  counts;
    pdbd_pkg::out_item_t res;
    gap = idle_gap(send_calm);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    counts = (it.req_type == pdbd_pkg::REQ_CODE_BIT) ? !stream_done
                                                     : (it.dict_index < pdbd_pkg::DictDepth);
    if (counts) fed_items++;
    predict_item(it, got, res);
    if (got) expected_bytes.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic send_write(input logic [6:0] idx, input logic [7:0] val);
    pdbd_pkg::in_item_t it;
    it.req_type = pdbd_pkg::REQ_DICT_WRITE;
    it.dict_index = idx;
    it.dict_value = val;
    it.code_bit = 1'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // Feed n code bits, most significant first; a typed result belongs to the last bit
  task automatic send_code(input logic [11:0] bits, input int unsigned n,
                           input bit typed, input pdbd_pkg::out_item_t want);
    pdbd_pkg::in_item_t it;
    for (int k = int'(n) - 1; k >= 0; k--) begin
      it.req_type = pdbd_pkg::REQ_CODE_BIT;
      it.dict_index = 7'($urandom);
      it.dict_value = 8'($urandom);
      it.code_bit = bits[k];
      // keep the end code out until the stream is meant to stop
      if (!end_allowed && !stream_done && code_len == 4'd7 &&
          {code_acc[6:0], it.code_bit} == 8'hFF) it.code_bit = 1'b0;
      send_item(it, typed && k == 0, want);
    end
  endtask

  task automatic send_random_code();
    case ($urandom_range(0, 9))
      0, 9:    send_code({4'b0000, 8'($urandom)}, 12, 1'b0, '0);
      1:       send_code(12'({2'b00, 2'($urandom_range(1, 3))}), 4, 1'b0, '0);
      2:       send_code(12'({3'b010, 2'($urandom)}), 5, 1'b0, '0);
      3:       send_code(12'({3'b011, 3'($urandom)}), 6, 1'b0, '0);
      4, 5:    send_code(12'({2'b10, 5'($urandom)}), 7, 1'b0, '0);
      default: send_code(12'({2'b11, 6'($urandom_range(0, 62))}), 8, 1'b0, '0);
    endcase
  endtask

  function automatic plan_row_t dict_row(input logic [6:0] idx, input logic [7:0] val);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic plan_row_t code_row(input logic [11:0] bits, input logic [3:0] n);
    plan_row_t r;
    r = '0;
    r.bits = bits;
    r.nbits = n;
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [11:0] bits, input logic [3:0] n,
                                         input logic [7:0] b, input logic fin);
    plan_row_t r;
    r = code_row(bits, n);
    r.typed = 1'b1;
    r.want.out_byte = b;
    r.want.stream_end = fin;
    return r;
  endfunction

  // Receiver: alternate ready runs and stalls of random length
  initial begin
    int unsigned hold;
    int unsigned stall;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else if (out_ready) begin
        stall = idle_gap(recv_calm);
        if (stall != 0) begin
          out_ready = 1'b0;
          hold = stall - 1;
        end else begin
          hold = $urandom_range(0, 7);
        end
      end else begin
        out_ready = 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 6);
      end
    end
  end

  // Compare each delivered item against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        if (mismatches < ReportMax)
          $display("result %0d: byte %02h end %0b arrived with nothing expected",
                   results_seen, out_data.out_byte, out_data.stream_end);
        mismatches++;
      end else begin
        want_now = expected_bytes.pop_front();
        if (out_data.out_byte !== want_now.out_byte ||
            out_data.stream_end !== want_now.stream_end) begin
          if (mismatches < ReportMax)
            $display("result %0d: expected byte %02h end %0b, got byte %02h end %0b",
                     results_seen, want_now.out_byte, want_now.stream_end,
                     out_data.out_byte, out_data.stream_end);
          mismatches++;
        end
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb_prefix_dictionary_byte_decoder_unit: errors");
      $finish;
    end
  end

  initial begin
    int unsigned random_goal;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    results_seen = 0;
    fed_items = 0;
    cycle_count = 0;
    send_calm = 0;
    recv_calm = 0;
    end_allowed = 1'b0;
    code_acc = '0;
    code_len = '0;
    hist_older = '0;
    hist_newer = '0;
    out_count = '0;
    stream_done = 1'b0;
    for (int i = 0; i < int'(pdbd_pkg::DictDepth); i++) dict_mirror[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Load every entry so that no code reads an unwritten one; delta off
    send_write(7'd0, 8'h00);
    for (int i = 1; i < int'(pdbd_pkg::DictDepth); i++) send_write(7'(i), 8'($urandom));

    // Directed plan: literal extremes, each code class at both ends of its range,
    // ignored writes, a write in the middle of a code, delta mode on and off
    plan.push_back(byte_row(12'b0000_00000000, 12, 8'h00, 1'b0));
    plan.push_back(byte_row(12'b0000_11111111, 12, 8'hFF, 1'b0));
    plan.push_back(code_row(12'b0001, 4));
    plan.push_back(code_row(12'b0011, 4));
    plan.push_back(code_row(12'b01000, 5));
    plan.push_back(code_row(12'b01011, 5));
    plan.push_back(code_row(12'b011000, 6));
    plan.push_back(code_row(12'b011111, 6));
    plan.push_back(code_row(12'b1000000, 7));
    plan.push_back(code_row(12'b1011111, 7));
    plan.push_back(code_row(12'b11000000, 8));
    plan.push_back(code_row(12'b11111110, 8));
    plan.push_back(dict_row(7'd127, 8'h5A));
    plan.push_back(dict_row(7'd111, 8'hA5));
    plan.push_back(dict_row(7'd110, 8'hFF));
    plan.push_back(byte_row(12'b11111110, 8, 8'hFF, 1'b0));
    plan.push_back(dict_row(7'd0, 8'h40));
    plan.push_back(code_row(12'b0000_00000000, 12));
    plan.push_back(code_row(12'b0000_11111111, 12));
    plan.push_back(code_row(12'b1011111, 7));
    plan.push_back(code_row(12'b10111, 5));
    plan.push_back(dict_row(7'd47, 8'h00));
    plan.push_back(code_row(12'b11, 2));
    plan.push_back(dict_row(7'd0, 8'hBF));
    plan.push_back(byte_row(12'b0000_10000000, 12, 8'h80, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].is_write) send_write(plan[i].idx, plan[i].val);
      else send_code(plan[i].bits, int'(plan[i].nbits), plan[i].typed, plan[i].want);
    end

    // Random stream: mostly whole codes, with dictionary rewrites, delta toggles
    // and stray bits that knock the code framing off
    random_goal = fed_items + RandomItems;
    send_write(7'd0, 8'($urandom));
    while (fed_items < random_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_write(7'($urandom), 8'($urandom));
      end else if (pick < 11) begin
        send_write(7'd0, 8'($urandom));
      end else if (pick < 16) begin
        send_code(12'($urandom), $urandom_range(1, 3), 1'b0, '0);
      end else begin
        send_random_code();
      end
    end

    // Finish any partial code so the end code starts on a code boundary
    while (code_len != 4'd0) send_code(12'd0, 1, 1'b0, '0);

    // Close the stream, then check that later bits are dropped
    end_allowed = 1'b1;
    send_code(12'b11111111, 8, 1'b1, '{8'h00, 1'b1});
    repeat (20) begin
      if ($urandom_range(0, 3) == 0) send_write(7'($urandom), 8'($urandom));
      else send_code(12'($urandom), 1, 1'b0, '0);
    end
    in_valid = 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_prefix_dictionary_byte_decoder_unit: clean");
    end else begin
      $display("tb_prefix_dictionary_byte_decoder_unit: errors");
    end
    $finish;
  end

endmodule
